// File: sv/mpiq_pkg.sv
// Shared types, register map and constant tables of the MPEG-2 inverse quantiser.
`timescale 1ns / 1ps
package mpiq_pkg;

    typedef struct packed {
        logic signed [11:0] coef;
        logic               intra;
        logic [4:0]         scale_code;
    } mpiq_in_t;

    typedef struct packed {
        logic signed [11:0] value;
        logic               last;
    } mpiq_out_t;

    // Control carried from the sequencer into the reconstruction stage
    typedef struct packed {
        logic dc;
        logic intra;
        logic last;
        logic parity;
    } mpiq_ctrl_t;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Register indexes, selected by paddr[2]
    localparam logic REG_NONLINEAR = 1'b0;
    localparam logic REG_DC_PREC   = 1'b1;

    localparam logic signed [11:0] VALUE_MAX = 12'sd2047;
    localparam logic signed [11:0] VALUE_MIN = -12'sd2048;

    localparam logic [6:0] FLAT_WEIGHT = 7'd16;

    localparam logic [6:0] INTRA_WEIGHT [64] = '{
        7'd8,  7'd16, 7'd19, 7'd22, 7'd26, 7'd27, 7'd29, 7'd34,
        7'd16, 7'd16, 7'd22, 7'd24, 7'd27, 7'd29, 7'd34, 7'd37,
        7'd19, 7'd22, 7'd26, 7'd27, 7'd29, 7'd34, 7'd34, 7'd38,
        7'd22, 7'd22, 7'd26, 7'd27, 7'd29, 7'd34, 7'd37, 7'd40,
        7'd22, 7'd26, 7'd27, 7'd29, 7'd32, 7'd35, 7'd40, 7'd48,
        7'd26, 7'd27, 7'd29, 7'd32, 7'd35, 7'd40, 7'd48, 7'd58,
        7'd26, 7'd27, 7'd29, 7'd34, 7'd38, 7'd46, 7'd56, 7'd69,
        7'd27, 7'd29, 7'd35, 7'd38, 7'd46, 7'd56, 7'd69, 7'd83
    };

    localparam logic [6:0] NONLINEAR_SCALE [32] = '{
        7'd0,  7'd1,  7'd2,  7'd3,  7'd4,  7'd5,  7'd6,   7'd7,
        7'd8,  7'd10, 7'd12, 7'd14, 7'd16, 7'd18, 7'd20,  7'd22,
        7'd24, 7'd28, 7'd32, 7'd36, 7'd40, 7'd44, 7'd48,  7'd52,
        7'd56, 7'd64, 7'd72, 7'd80, 7'd88, 7'd96, 7'd104, 7'd112
    };

endpackage

// File: sv/mpiq_recon.sv
// Divide with truncation toward zero (DC undivided), 12-bit saturation and mismatch control.
`timescale 1ns / 1ps
module mpiq_recon
    import mpiq_pkg::*;
(
    input  logic signed [27:0] product,
    input  mpiq_ctrl_t         ctrl,
    output logic signed [11:0] value,
    output logic               parity_out
);

    logic               neg;
    logic signed [27:0] biased;
    logic signed [27:0] quot;
    logic signed [11:0] sat;
    logic               parity_new;

    always_comb begin
        neg = product[27];
        // Bias negative values so the arithmetic shift truncates toward zero
        if (ctrl.dc) begin
            biased = product;
            quot   = biased;
        end else if (ctrl.intra) begin
            biased = product + (neg ? 28'sd15 : 28'sd0);
            quot   = biased >>> 4;
        end else begin
            biased = product + (neg ? 28'sd31 : 28'sd0);
            quot   = biased >>> 5;
        end

        if (quot > 28'(VALUE_MAX)) begin
            sat = VALUE_MAX;
        end else if (quot < 28'(VALUE_MIN)) begin
            sat = VALUE_MIN;
        end else begin
            sat = quot[11:0];
        end

        parity_new = ctrl.parity ^ sat[0];
        // Even block sum: toggle the LSB of the last coefficient
        if (ctrl.last) begin
            value      = sat ^ {11'd0, ~parity_new};
            parity_out = 1'b0;
        end else begin
            value      = sat;
            parity_out = parity_new;
        end
    end

endmodule

// File: sv/mpeg2_inverse_quantiser_unit.sv
// Top level of the MPEG-2 inverse quantiser: sequencer, shared multiplier, APB registers.
//
//  Channel  Ports                        Carries
//  -------  ---------------------------  ------------------------------------------
//  input    s_valid s_ready s_data       quantised coef, intra flag, scale code
//  result   m_valid m_ready m_data       saturated value, last-of-block flag
//  config   psel penable pwrite paddr    nonlinear_scale at 0x0, dc_precision at 0x4
//           pwdata prdata pready
//
// Each coefficient goes through one multiplier pass at acceptance (coefficient by weight),
// a second pass (by quantiser scale), then reconstruction into the output register.
// Both passes use the single shared multiplier.
// Synchronous active-low reset clears position, parity, registers and the output valid.
// A stalled result holds the sequencer in its final step; input is taken while the
// previous result still waits.
`timescale 1ns / 1ps
module mpeg2_inverse_quantiser_unit
    import mpiq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  mpiq_in_t              s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output mpiq_out_t             m_data,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic               nonlinear_reg;
    logic [1:0]         dc_prec_reg;
    logic [5:0]         position_reg;
    logic               parity_reg;

    logic signed [19:0] p1_reg;
    logic signed [27:0] p2_reg;
    logic [6:0]         qs_reg, qs_next;
    mpiq_ctrl_t         ctrl_reg, ctrl_next;

    logic               m_valid_reg;
    mpiq_out_t          m_data_reg;

    logic               in_take;
    logic               out_load;
    logic               cfg_write;
    logic               is_dc;
    logic signed [13:0] coef_x;
    logic signed [13:0] op_a1;
    logic [6:0]         op_b1;
    logic signed [19:0] mul_a;
    logic [6:0]         mul_b;
    logic signed [28:0] product;
    logic signed [11:0] recon_value;
    logic               recon_parity;

    assign in_take   = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_NONLINEAR: prdata = {{(APB_DATA_W-1){1'b0}}, nonlinear_reg};
            REG_DC_PREC:   prdata = {{(APB_DATA_W-2){1'b0}}, dc_prec_reg};
            default:       prdata = '0;
        endcase
    end

    // First multiplier operands, formed straight from the incoming transaction
    always_comb begin
        is_dc  = s_data.intra && (position_reg == 6'd0);
        coef_x = {{2{s_data.coef[11]}}, s_data.coef};
        if (s_data.intra || s_data.coef == 12'sd0) begin
            op_a1 = coef_x;
        end else if (s_data.coef[11]) begin
            op_a1 = (coef_x <<< 1) - 14'sd1;
        end else begin
            op_a1 = (coef_x <<< 1) + 14'sd1;
        end

        if (is_dc) begin
            op_b1 = 7'(4'd8 >> dc_prec_reg);
        end else if (s_data.intra) begin
            op_b1 = INTRA_WEIGHT[position_reg];
        end else begin
            op_b1 = FLAT_WEIGHT;
        end

        // DC passes through the second multiply unscaled
        if (is_dc) begin
            qs_next = 7'd1;
        end else if (nonlinear_reg) begin
            qs_next = NONLINEAR_SCALE[s_data.scale_code];
        end else begin
            qs_next = {1'b0, s_data.scale_code, 1'b0};
        end

        ctrl_next.dc     = is_dc;
        ctrl_next.intra  = s_data.intra;
        ctrl_next.last   = (position_reg == 6'd63);
        ctrl_next.parity = parity_reg;
    end

    // Shared multiplier
    always_comb begin
        if (state_reg == ST_MUL) begin
            mul_a = p1_reg;
            mul_b = qs_reg;
        end else begin
            mul_a = {{6{op_a1[13]}}, op_a1};
            mul_b = op_b1;
        end
        product = mul_a * $signed({1'b0, mul_b});
    end

    mpiq_recon u_recon (
        .product    (p2_reg),
        .ctrl       (ctrl_reg),
        .value      (recon_value),
        .parity_out (recon_parity)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_take)  state_next = ST_MUL;
            ST_MUL:                state_next = ST_FIN;
            ST_FIN:  if (out_load) state_next = ST_IDLE;
            default:               state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            nonlinear_reg <= 1'b0;
            dc_prec_reg   <= 2'd0;
            position_reg  <= 6'd0;
            parity_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_write) begin
                case (paddr[2])
                    REG_NONLINEAR: nonlinear_reg <= pwdata[0];
                    REG_DC_PREC:   dc_prec_reg   <= pwdata[1:0];
                    default:       nonlinear_reg <= nonlinear_reg;
                endcase
            end
            if (out_load) begin
                m_valid_reg  <= 1'b1;
                position_reg <= position_reg + 6'd1;
                parity_reg   <= recon_parity;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            p1_reg   <= product[19:0];
            qs_reg   <= qs_next;
            ctrl_reg <= ctrl_next;
        end
        if (state_reg == ST_MUL) begin
            p2_reg <= product[27:0];
        end
        if (out_load) begin
            m_data_reg.value <= recon_value;
            m_data_reg.last  <= ctrl_reg.last;
        end
    end

endmodule

// File: sv/mpiq_checker.sv
// Port-level assertions for the inverse quantiser, bound to the top level.
`timescale 1ns / 1ps
module mpiq_checker
    import mpiq_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input mpiq_out_t m_data
);

    // Busy through the second multiplier pass and the final step after each transaction
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input taken while a coefficient is in flight");

    // A result never appears before both multiplier passes of its transaction are done
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (!m_valid || m_ready) |=> !m_valid ##1 !m_valid)
        else $error("result produced before the multiplier passes finished");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result dropped or changed");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset left a result pending or the input blocked");

endmodule

bind mpeg2_inverse_quantiser_unit mpiq_checker u_mpiq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
